>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: always");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/idsm_pkg.sv
package idsm_pkg;

  // Field widths fixed by the interface
  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;

  // Default table size
  localparam int SLOTS_DEFAULT = 64;

  // Operation codes; the unused code behaves as a lookup
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_FOUND  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd4;

endpackage

>>> rtl/id_slot_map_table_top.sv
// Channel   Handshake              Payload
// request   start, accepted !busy  operation, key_id
// result    done, one-cycle strobe status, slot_index
//
// A zero id answers in the cycle after acceptance, without a scan.
// Any other request scans the filled range of the slot memory, one read a
// cycle through its single read port, ending early on a match. busy stays
// high until the result beat. Reset clears the fill count and control
// state, not the slot memory; slots at or above the count are never read
// before being written, so no clearing pass is needed. Results cannot stall.
`include "assert_macros.svh"

module id_slot_map_table_top #(
  parameter int SLOTS = idsm_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [idsm_pkg::OP_W-1:0]      operation,
  input  logic [idsm_pkg::KEY_W-1:0]     key_id,
  output logic                           done,
  output logic [idsm_pkg::STATUS_W-1:0]  status,
  output logic [idsm_pkg::SLOT_W-1:0]    slot_index
);
  import idsm_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int FW = $clog2(SLOTS + 1);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_SCAN = 1'b1;

  logic [0:0]       state;
  logic [OP_W-1:0]  op_q;
  logic [KEY_W-1:0] key_q;
  logic [FW-1:0]    fill_count;
  logic [FW-1:0]    iss;
  logic [AW-1:0]    cmp_idx;
  logic             cmp_vld;
  logic             free_found;
  logic [AW-1:0]    free_idx;

  logic [KEY_W-1:0] slot_mem [SLOTS];
  logic [KEY_W-1:0] rdata;

  logic             hit;
  logic             scan_end;
  logic             room;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [KEY_W-1:0] mem_wdata;
  logic [AW+SLOT_W-1:0] hit_ext;
  logic [AW+SLOT_W-1:0] fill_ext;
  logic [AW+SLOT_W-1:0] free_ext;

  assign busy     = (state == S_SCAN);
  assign hit      = cmp_vld && (rdata == key_q);
  assign scan_end = (state == S_SCAN) && (hit || (!cmp_vld && (iss == fill_count)));
  assign room     = (fill_count < FW'(SLOTS));
  assign hit_ext  = {{SLOT_W{1'b0}}, cmp_idx};
  assign fill_ext = {{SLOT_W{1'b0}}, fill_count[AW-1:0]};
  assign free_ext = {{SLOT_W{1'b0}}, free_idx};

  // Pick the write-back at the end of a scan
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmp_idx;
    mem_wdata = '0;
    if (scan_end) begin
      if (hit) begin
        if (op_q == OP_FREE) begin
          mem_we = 1'b1;
        end
      end else if (op_q == OP_GET) begin
        if (room) begin
          mem_we    = 1'b1;
          mem_waddr = fill_count[AW-1:0];
          mem_wdata = key_q;
        end else if (free_found) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx;
          mem_wdata = key_q;
        end
      end
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= slot_mem[iss[AW-1:0]];
  end

  // Sequencer, scan pipeline and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      done       <= 1'b0;
      cmp_vld    <= 1'b0;
      free_found <= 1'b0;
      iss        <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q       <= operation;
            key_q      <= key_id;
            iss        <= '0;
            cmp_vld    <= 1'b0;
            free_found <= 1'b0;
            if (key_id == '0) begin
              done       <= 1'b1;
              status     <= ST_ZERO;
              slot_index <= '0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue the next read while the range lasts
          if (iss != fill_count) begin
            iss     <= iss + FW'(1);
            cmp_idx <= iss[AW-1:0];
            cmp_vld <= 1'b1;
          end else begin
            cmp_vld <= 1'b0;
          end
          // Note the lowest free slot seen
          if (cmp_vld && !hit && (rdata == '0) && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
          // Finish: answer and update the fill count
          if (scan_end) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (hit) begin
              status     <= ST_FOUND;
              slot_index <= hit_ext[SLOT_W-1:0];
              if ((op_q == OP_FREE) && (FW'(cmp_idx) + FW'(1) == fill_count)) begin
                fill_count <= fill_count - FW'(1);
              end
            end else if (op_q == OP_GET) begin
              if (room) begin
                status     <= ST_ALLOC;
                slot_index <= fill_ext[SLOT_W-1:0];
                fill_count <= fill_count + FW'(1);
              end else if (free_found) begin
                status     <= ST_ALLOC;
                slot_index <= free_ext[SLOT_W-1:0];
              end else begin
                status     <= ST_FULL;
                slot_index <= '0;
              end
            end else begin
              status     <= ST_ABSENT;
              slot_index <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_fill_bound, clk, rst, fill_count <= FW'(SLOTS))
  `ASSERT_IMPLY(a_slot_zero, clk, rst, done && (status != ST_FOUND) && (status != ST_ALLOC), slot_index == '0)
  `ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, busy || done)
  `ASSERT_IMPLY(a_read_in_range, clk, rst, busy && cmp_vld, FW'(cmp_idx) < fill_count)

endmodule
